>>> design/gaai_pkg.sv
// ----------------------------------------------------------------------------
// gaai_pkg
// Shared types and constants for the adjacency arc insert block.
// ----------------------------------------------------------------------------
`default_nettype none

package gaai_pkg;

  localparam int VID_W  = 31;  // vertex identifier
  localparam int WGT_W  = 32;  // arc weight, two's complement
  localparam int STAT_W = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_NEW      = 2'd0,
    ST_REPLACED = 2'd1,
    ST_FULL_A   = 2'd2,
    ST_FULL_B   = 2'd3
  } status_t;

  // search token flags, travelling along the cell chain
  typedef struct packed {
    logic valid;
    logic found;
    logic inserted;
  } flags_t;

endpackage : gaai_pkg

`default_nettype wire

>>> design/gaai_ram.sv
// ----------------------------------------------------------------------------
// gaai_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gaai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : gaai_ram

`default_nettype wire

>>> design/gaai_cell.sv
// ----------------------------------------------------------------------------
// gaai_cell
// One vertex table slot: holds an identifier, matches or claims a passing
// search token and hands the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module gaai_cell #(
  parameter int IDX    = 0,
  parameter int SLOT_W = 6,
  parameter int VCNT_W = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gaai_pkg::flags_t           flags_i,
  input  logic [gaai_pkg::VID_W-1:0] key_i,
  input  logic [SLOT_W-1:0]          slot_i,
  input  logic [VCNT_W-1:0]          count_i,
  output gaai_pkg::flags_t           flags_o,
  output logic [gaai_pkg::VID_W-1:0] key_o,
  output logic [SLOT_W-1:0]          slot_o
);

  import gaai_pkg::*;

  logic [VID_W-1:0]  id_r, id_nxt;
  flags_t            flg_r, flg_nxt;
  logic [VID_W-1:0]  key_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              live, hit, claim;

  // slots below the fill count are occupied; the slot at the count is free
  assign live  = flags_i.valid && !flags_i.found;
  assign hit   = live && (VCNT_W'(IDX) < count_i) && (id_r == key_i);
  assign claim = live && (VCNT_W'(IDX) == count_i);

  always_comb begin
    flg_nxt  = flags_i;
    slot_nxt = slot_i;
    id_nxt   = id_r;
    if (hit) begin
      flg_nxt.found = 1'b1;
      slot_nxt      = SLOT_W'(IDX);
    end else if (claim) begin
      flg_nxt.found    = 1'b1;
      flg_nxt.inserted = 1'b1;
      slot_nxt         = SLOT_W'(IDX);
      id_nxt           = key_i;
    end
  end

  // only the token valid bit needs a reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_r.valid <= 1'b0;
    end else begin
      flg_r.valid <= flg_nxt.valid;
    end
    flg_r.found    <= flg_nxt.found;
    flg_r.inserted <= flg_nxt.inserted;
    key_r          <= key_i;
    slot_r         <= slot_nxt;
    id_r           <= id_nxt;
  end

  assign flags_o = flg_r;
  assign key_o   = key_r;
  assign slot_o  = slot_r;

endmodule : gaai_cell

`default_nettype wire

>>> design/graph_adjacency_arc_insert.sv
// ----------------------------------------------------------------------------
// graph_adjacency_arc_insert
// Undirected weighted adjacency store with a vertex table filled in arrival
// order. An arc beat is taken when start is high and busy is low. Each
// endpoint identifier is searched in a chain of MAX_VERTICES cells; a new
// one claims the next free slot. The weight goes into both symmetric cells
// of the weight store, and a presence store (one row per lower slot, one
// bit per upper slot) tells a new arc from a replaced one. Exactly one
// result beat follows each arc, on the out_ ports for a single cycle with
// out_strobe high; the receiver cannot stall it. Each accepted arc runs
// two passes of the search token down the cell chain, then the presence
// read-modify-write and the second weight write, before the next arc can
// be taken. An arc whose first endpoint finds the table full finishes
// after the first pass, one whose second endpoint does after the second.
// After reset the block clears the presence store, one row a cycle, and
// holds busy high until the last row is cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_adjacency_arc_insert #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // arc input
  input  logic                                         start,
  output logic                                         busy,
  input  logic [gaai_pkg::VID_W-1:0]                   in_vertex_a,
  input  logic [gaai_pkg::VID_W-1:0]                   in_vertex_b,
  input  logic signed [gaai_pkg::WGT_W-1:0]            in_weight,
  // result
  output logic                                         out_strobe,
  output logic [gaai_pkg::STAT_W-1:0]                  out_status,
  output logic [$clog2(MAX_VERTICES)-1:0]              out_slot_a,
  output logic [$clog2(MAX_VERTICES)-1:0]              out_slot_b,
  output logic [$clog2(MAX_VERTICES+1)-1:0]            out_vertices_held,
  output logic [$clog2(MAX_VERTICES*(MAX_VERTICES+1)/2+1)-1:0] out_arcs_held
);

  import gaai_pkg::*;

  localparam int SLOT_W    = $clog2(MAX_VERTICES);
  localparam int VCNT_W    = $clog2(MAX_VERTICES + 1);
  localparam int ARC_W     = $clog2(MAX_VERTICES * (MAX_VERTICES + 1) / 2 + 1);
  localparam int WGT_DEPTH = 2 ** (2 * SLOT_W);

  // one-hot sequencer
  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,  // presence store clearing pass
    S_IDLE    = 7'b0000010,
    S_SRCH_A  = 7'b0000100,  // token for vertex_a in the chain
    S_SRCH_B  = 7'b0001000,  // token for vertex_b in the chain
    S_ROW_RD  = 7'b0010000,  // presence row read
    S_ROW_UPD = 7'b0100000,  // presence update, first weight write
    S_WGT2    = 7'b1000000   // mirrored weight write, result beat
  } state_t;

  state_t              state_r, state_nxt;
  logic [VCNT_W-1:0]   vcount_r, vcount_nxt;
  logic [ARC_W-1:0]    acount_r, acount_nxt;
  logic [SLOT_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic                hd_valid_r, hd_valid_nxt;
  logic [VID_W-1:0]    hd_key_r, hd_key_nxt;
  logic [VID_W-1:0]    key_b_r, key_b_nxt;
  logic [WGT_W-1:0]    wgt_r, wgt_nxt;
  logic [SLOT_W-1:0]   slot_a_r, slot_a_nxt;
  logic [SLOT_W-1:0]   slot_b_r, slot_b_nxt;
  status_t             stat_r, stat_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_a_r, out_slot_a_nxt;
  logic [SLOT_W-1:0]   out_slot_b_r, out_slot_b_nxt;
  logic [VCNT_W-1:0]   out_vheld_r, out_vheld_nxt;
  logic [ARC_W-1:0]    out_aheld_r, out_aheld_nxt;

  // cell chain taps: stage 0 is the head register, stage N the tail
  flags_t              st_flags [MAX_VERTICES+1];
  logic [VID_W-1:0]    st_key   [MAX_VERTICES+1];
  logic [SLOT_W-1:0]   st_slot  [MAX_VERTICES+1];
  logic [MAX_VERTICES:0] tok_valid;

  // presence store and weight store ports
  logic                    pres_we, pres_re;
  logic [SLOT_W-1:0]       pres_waddr;
  logic [MAX_VERTICES-1:0] pres_wdata, pres_rdata, hi_mask;
  logic [SLOT_W-1:0]       row_lo, row_hi;
  logic                    wgt_we;
  logic [2*SLOT_W-1:0]     wgt_waddr;

  // --------------------------------------------------------------------------
  // Vertex table: chain of search cells
  // --------------------------------------------------------------------------
  assign st_flags[0] = '{valid: hd_valid_r, found: 1'b0, inserted: 1'b0};
  assign st_key[0]   = hd_key_r;
  assign st_slot[0]  = '0;

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    gaai_cell #(
      .IDX    (g),
      .SLOT_W (SLOT_W),
      .VCNT_W (VCNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .flags_i (st_flags[g]),
      .key_i   (st_key[g]),
      .slot_i  (st_slot[g]),
      .count_i (vcount_r),
      .flags_o (st_flags[g+1]),
      .key_o   (st_key[g+1]),
      .slot_o  (st_slot[g+1])
    );
  end

  for (genvar k = 0; k <= MAX_VERTICES; k++) begin : g_tokv
    assign tok_valid[k] = st_flags[k].valid;
  end

  // --------------------------------------------------------------------------
  // Adjacency stores
  // --------------------------------------------------------------------------
  // presence is symmetric, so only the (lower, upper) bit is kept
  assign row_lo = (slot_a_r < slot_b_r) ? slot_a_r : slot_b_r;
  assign row_hi = (slot_a_r < slot_b_r) ? slot_b_r : slot_a_r;

  always_comb begin
    hi_mask         = '0;
    hi_mask[row_hi] = 1'b1;
  end

  gaai_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_pres_ram (
    .clk     (clk),
    .wr_en   (pres_we),
    .wr_addr (pres_waddr),
    .wr_data (pres_wdata),
    .rd_en   (pres_re),
    .rd_addr (row_lo),
    .rd_data (pres_rdata)
  );

  // weights are stored but never read back by the arc sequence
  gaai_ram #(
    .WIDTH (WGT_W),
    .DEPTH (WGT_DEPTH)
  ) u_wgt_ram (
    .clk     (clk),
    .wr_en   (wgt_we),
    .wr_addr (wgt_waddr),
    .wr_data (wgt_r),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    vcount_nxt     = vcount_r;
    acount_nxt     = acount_r;
    clr_idx_nxt    = clr_idx_r;
    hd_valid_nxt   = 1'b0;
    hd_key_nxt     = hd_key_r;
    key_b_nxt      = key_b_r;
    wgt_nxt        = wgt_r;
    slot_a_nxt     = slot_a_r;
    slot_b_nxt     = slot_b_r;
    stat_nxt       = stat_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_a_nxt = out_slot_a_r;
    out_slot_b_nxt = out_slot_b_r;
    out_vheld_nxt  = out_vheld_r;
    out_aheld_nxt  = out_aheld_r;
    pres_we        = 1'b0;
    pres_re        = 1'b0;
    pres_waddr     = clr_idx_r;
    pres_wdata     = '0;
    wgt_we         = 1'b0;
    wgt_waddr      = {slot_a_r, slot_b_r};

    unique case (state_r)
      S_CLEAR: begin
        pres_we     = 1'b1;
        clr_idx_nxt = clr_idx_r + SLOT_W'(1);
        if (clr_idx_r == SLOT_W'(MAX_VERTICES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          hd_valid_nxt = 1'b1;
          hd_key_nxt   = in_vertex_a;
          key_b_nxt    = in_vertex_b;
          wgt_nxt      = in_weight;
          state_nxt    = S_SRCH_A;
        end
      end
      S_SRCH_A: begin
        if (st_flags[MAX_VERTICES].valid) begin
          if (st_flags[MAX_VERTICES].found) begin
            slot_a_nxt = st_slot[MAX_VERTICES];
            if (st_flags[MAX_VERTICES].inserted) begin
              vcount_nxt = vcount_r + VCNT_W'(1);
            end
            // head is registered, so cell 0 already sees the new count
            hd_valid_nxt = 1'b1;
            hd_key_nxt   = key_b_r;
            state_nxt    = S_SRCH_B;
          end else begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = ST_FULL_A;
            out_slot_a_nxt = '0;
            out_slot_b_nxt = '0;
            out_vheld_nxt  = vcount_r;
            out_aheld_nxt  = acount_r;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_SRCH_B: begin
        if (st_flags[MAX_VERTICES].valid) begin
          if (st_flags[MAX_VERTICES].found) begin
            slot_b_nxt = st_slot[MAX_VERTICES];
            if (st_flags[MAX_VERTICES].inserted) begin
              vcount_nxt = vcount_r + VCNT_W'(1);
            end
            state_nxt = S_ROW_RD;
          end else begin
            // first endpoint stays in the table
            out_strobe_nxt = 1'b1;
            out_status_nxt = ST_FULL_B;
            out_slot_a_nxt = slot_a_r;
            out_slot_b_nxt = '0;
            out_vheld_nxt  = vcount_r;
            out_aheld_nxt  = acount_r;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_ROW_RD: begin
        pres_re   = 1'b1;
        state_nxt = S_ROW_UPD;
      end
      S_ROW_UPD: begin
        pres_we    = 1'b1;
        pres_waddr = row_lo;
        pres_wdata = pres_rdata | hi_mask;
        wgt_we     = 1'b1;
        if (pres_rdata[row_hi]) begin
          stat_nxt = ST_REPLACED;
        end else begin
          stat_nxt   = ST_NEW;
          acount_nxt = acount_r + ARC_W'(1);
        end
        state_nxt = S_WGT2;
      end
      S_WGT2: begin
        wgt_we         = 1'b1;
        wgt_waddr      = {slot_b_r, slot_a_r};
        out_strobe_nxt = 1'b1;
        out_status_nxt = stat_r;
        out_slot_a_nxt = slot_a_r;
        out_slot_b_nxt = slot_b_r;
        out_vheld_nxt  = vcount_r;
        out_aheld_nxt  = acount_r;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      vcount_r     <= '0;
      acount_r     <= '0;
      clr_idx_r    <= '0;
      hd_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vcount_r     <= vcount_nxt;
      acount_r     <= acount_nxt;
      clr_idx_r    <= clr_idx_nxt;
      hd_valid_r   <= hd_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hd_key_r     <= hd_key_nxt;
    key_b_r      <= key_b_nxt;
    wgt_r        <= wgt_nxt;
    slot_a_r     <= slot_a_nxt;
    slot_b_r     <= slot_b_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_slot_a_r <= out_slot_a_nxt;
    out_slot_b_r <= out_slot_b_nxt;
    out_vheld_r  <= out_vheld_nxt;
    out_aheld_r  <= out_aheld_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_slot_a        = out_slot_a_r;
  assign out_slot_b        = out_slot_b_r;
  assign out_vertices_held = out_vheld_r;
  assign out_arcs_held     = out_aheld_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // never more than one search token in flight
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valid) <= 1)
    else $error("more than one search token in the cell chain");

  // a token only leaves the chain while a search is under way
  a_tail_state: assert property (@(posedge clk) disable iff (!rst_n)
    st_flags[MAX_VERTICES].valid |-> (state_r == S_SRCH_A || state_r == S_SRCH_B))
    else $error("search token left the chain outside a search");

  // fill count stays within the table
  a_vcount: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= VCNT_W'(MAX_VERTICES))
    else $error("vertex count beyond table size");

  // a new arc advances the stored arc count by one
  a_new_arc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW_UPD && !pres_rdata[row_hi])
      |=> (acount_r == $past(acount_r) + ARC_W'(1)))
    else $error("arc count not advanced on new arc");

endmodule : graph_adjacency_arc_insert

`default_nettype wire

>>> dv/tb_graph_adjacency_arc_insert.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_graph_adjacency_arc_insert
// Self-checking bench for the adjacency arc insert block. A queue of arc
// beats is built up front: a short directed set of extreme identifiers and
// weights, then random arcs that fill the vertex table, walk it through both
// table-full cases and keep re-hitting a few hot vertices so that weight
// replacements are frequent. A clocked driver feeds the beats with random
// idle bursts; a clocked monitor checks every result beat against a local
// prediction of the vertex table and the arc presence matrix.
// ----------------------------------------------------------------------------

module tb_graph_adjacency_arc_insert;

  import gaai_pkg::*;

  localparam int MAXV      = 64;
  localparam int SLOT_W    = $clog2(MAXV);
  localparam int HELD_W    = $clog2(MAXV + 1);
  localparam int ARCS_W    = $clog2(MAXV * (MAXV + 1) / 2 + 1);
  localparam int N_ITEMS   = 1250;
  localparam int CALM_TAIL = 150;   // last beats are sent without idling
  localparam int HOT_VERTS = 6;     // hot set that drives weight replacements

  typedef logic [VID_W-1:0]        vid_t;
  typedef logic signed [WGT_W-1:0] wgt_t;

  typedef struct {
    vid_t vertex_a;
    vid_t vertex_b;
    wgt_t weight;
  } arc_beat_t;

  typedef struct {
    status_t            status;
    logic [SLOT_W-1:0]  slot_a;
    logic [SLOT_W-1:0]  slot_b;
    logic [HELD_W-1:0]  vertices_held;
    logic [ARCS_W-1:0]  arcs_held;
  } arc_report_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input known from time zero
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  vid_t in_vertex_a = '0;
  vid_t in_vertex_b = '0;
  wgt_t in_weight   = '0;

  logic              busy;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot_a;
  logic [SLOT_W-1:0] out_slot_b;
  logic [HELD_W-1:0] out_vertices_held;
  logic [ARCS_W-1:0] out_arcs_held;

  graph_adjacency_arc_insert #(
    .MAX_VERTICES(MAXV)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_vertex_a      (in_vertex_a),
    .in_vertex_b      (in_vertex_b),
    .in_weight        (in_weight),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_slot_a       (out_slot_a),
    .out_slot_b       (out_slot_b),
    .out_vertices_held(out_vertices_held),
    .out_arcs_held    (out_arcs_held)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predicted block state. Weights are never visible at the outputs, so only
  // the presence matrix is tracked.
  // --------------------------------------------------------------------------
  vid_t        vtab_ids [MAXV];
  int          vtab_count = 0;
  bit          linked   [MAXV][MAXV];
  int          link_count = 0;
  arc_report_t arc_reports_due [$];

  // look an identifier up; a new one claims the next free slot if any
  task automatic claim_slot(input vid_t id, output bit ok, output int slot);
    int i;
    ok   = 1'b0;
    slot = 0;
    for (i = 0; i < vtab_count; i++) begin
      if (!ok && vtab_ids[i] == id) begin
        ok   = 1'b1;
        slot = i;
      end
    end
    if (!ok && vtab_count < MAXV) begin
      vtab_ids[vtab_count] = id;
      slot = vtab_count;
      vtab_count++;
      ok = 1'b1;
    end
  endtask

  // apply one accepted arc to the predicted state and queue its result
  task automatic place_arc(input vid_t a, input vid_t b);
    arc_report_t r;
    bit          ok_a;
    bit          ok_b;
    int          sa;
    int          sb;
    claim_slot(a, ok_a, sa);
    sb = 0;
    if (!ok_a) begin
      // first endpoint refused: nothing changes
      r.status = ST_FULL_A;
      sa = 0;
    end else begin
      claim_slot(b, ok_b, sb);
      if (!ok_b) begin
        // first endpoint may have just been inserted; it stays
        r.status = ST_FULL_B;
        sb = 0;
      end else begin
        if (linked[sa][sb]) begin
          r.status = ST_REPLACED;
        end else begin
          r.status = ST_NEW;
          link_count++;
        end
        linked[sa][sb] = 1'b1;
        linked[sb][sa] = 1'b1;
      end
    end
    r.slot_a        = SLOT_W'(sa);
    r.slot_b        = SLOT_W'(sb);
    r.vertices_held = HELD_W'(vtab_count);
    r.arcs_held     = ARCS_W'(link_count);
    arc_reports_due.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus build. gen_ids mirrors the table contents as the beats will
  // leave it, so random arcs can aim at known or fresh vertices.
  // --------------------------------------------------------------------------
  arc_beat_t arcs_to_send [$];
  vid_t      gen_ids [$];

  function automatic bit in_pool(input vid_t id);
    foreach (gen_ids[i]) begin
      if (gen_ids[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic vid_t fresh_id();
    vid_t id;
    do begin
      if ($urandom_range(0, 3) == 0) id = vid_t'($urandom_range(0, 31));
      else id = vid_t'($urandom());
    end while (in_pool(id));
    return id;
  endfunction

  // at least half the picks land on the hot set so arcs get rewritten
  function automatic vid_t known_id();
    int hi;
    hi = gen_ids.size() - 1;
    if ($urandom_range(0, 1) == 1 && hi >= HOT_VERTS) hi = HOT_VERTS - 1;
    return gen_ids[$urandom_range(0, hi)];
  endfunction

  task automatic queue_arc(input vid_t a, input vid_t b, input wgt_t w);
    arc_beat_t beat;
    beat.vertex_a = a;
    beat.vertex_b = b;
    beat.weight   = w;
    arcs_to_send.push_back(beat);
    if (!in_pool(a)) begin
      if (gen_ids.size() >= MAXV) return;
      gen_ids.push_back(a);
    end
    if (!in_pool(b) && gen_ids.size() < MAXV) gen_ids.push_back(b);
  endtask

  // --------------------------------------------------------------------------
  // Driver: beats leave the queue in order; idle gaps only count down while
  // the block is free, so they land on the cycles where it could take a beat.
  // --------------------------------------------------------------------------
  int arcs_sent  = 0;
  int gap_left   = 0;
  int quiet_left = 0;
  bit took;
  arc_beat_t next_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        place_arc(in_vertex_a, in_vertex_b);
        arcs_sent++;
        if (arcs_sent < N_ITEMS - CALM_TAIL) begin
          if (quiet_left > 0) quiet_left--;
          else if ($urandom_range(0, 7) == 0) quiet_left = $urandom_range(5, 20);
          else if ($urandom_range(0, 1) == 1) gap_left = $urandom_range(1, 11);
        end
      end
      if (took || !start) begin
        if (gap_left > 0 && !took && !busy) gap_left--;
        if (gap_left > 0) begin
          start <= 1'b0;
        end else if (arcs_to_send.size() > 0) begin
          next_beat   = arcs_to_send.pop_front();
          in_vertex_a <= next_beat.vertex_a;
          in_vertex_b <= next_beat.vertex_b;
          in_weight   <= next_beat.weight;
          start       <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobed result beat is checked against the oldest
  // prediction, field by field.
  // --------------------------------------------------------------------------
  int          mismatches = 0;
  int          status_tally [4];
  arc_report_t want;

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      status_tally[out_status]++;
      if (arc_reports_due.size() == 0) begin
        $error("result beat with no arc outstanding (status %0d)", out_status);
        mismatches++;
      end else begin
        want = arc_reports_due.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatches++;
        end
        if (out_slot_a !== want.slot_a) begin
          $error("slot_a: expected %0d, actual %0d", want.slot_a, out_slot_a);
          mismatches++;
        end
        if (out_slot_b !== want.slot_b) begin
          $error("slot_b: expected %0d, actual %0d", want.slot_b, out_slot_b);
          mismatches++;
        end
        if (out_vertices_held !== want.vertices_held) begin
          $error("vertices_held: expected %0d, actual %0d",
                 want.vertices_held, out_vertices_held);
          mismatches++;
        end
        if (out_arcs_held !== want.arcs_held) begin
          $error("arcs_held: expected %0d, actual %0d", want.arcs_held, out_arcs_held);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build beats, reset, run, drain, report
  // --------------------------------------------------------------------------
  initial begin
    bit   edges_done;
    int   p_new;
    vid_t a;
    vid_t b;

    edges_done = 1'b0;

    // directed: extreme identifiers, self loops, symmetric rewrite,
    // and weights at both ends including the most negative one
    queue_arc(vid_t'(0), {VID_W{1'b1}}, 32'sh7FFF_FFFF);
    queue_arc({VID_W{1'b1}}, vid_t'(0), 32'sh8000_0000);
    queue_arc(vid_t'(0), vid_t'(0), 32'sh0000_0000);
    queue_arc(vid_t'(0), vid_t'(0), -32'sd1);
    queue_arc({VID_W{1'b1}}, {VID_W{1'b1}}, 32'sh8000_0001);
    queue_arc(31'h2AAA_AAAA, 31'h5555_5555, 32'shAAAA_AAAA);
    queue_arc(31'h5555_5555, 31'h2AAA_AAAA, 32'sh5555_5555);
    queue_arc(31'h2AAA_AAAA, vid_t'(0), 32'sd1);
    queue_arc({VID_W{1'b1}}, 31'h5555_5555, 32'sh8000_0000);
    queue_arc(31'h5555_5555, 31'h5555_5555, 32'sh7FFF_FFFF);

    while (arcs_to_send.size() < N_ITEMS) begin
      if (!edges_done && gen_ids.size() >= MAXV - 2) begin
        // walk the table into both full cases
        if (gen_ids.size() == MAXV - 2) queue_arc(fresh_id(), known_id(), wgt_t'($urandom()));
        queue_arc(fresh_id(), fresh_id(), wgt_t'($urandom()));  // a taken, b refused
        queue_arc(fresh_id(), known_id(), wgt_t'($urandom()));  // a refused
        queue_arc(known_id(), fresh_id(), wgt_t'($urandom()));  // b refused
        queue_arc(fresh_id(), fresh_id(), wgt_t'($urandom()));
        queue_arc(fresh_id(), fresh_id(), wgt_t'($urandom()));
        edges_done = 1'b1;
      end else begin
        p_new = (gen_ids.size() < MAXV) ? 35 : 6;
        a = ($urandom_range(0, 99) < p_new) ? fresh_id() : known_id();
        if ($urandom_range(0, 15) == 0) b = a;
        else b = ($urandom_range(0, 99) < p_new) ? fresh_id() : known_id();
        queue_arc(a, b, wgt_t'($urandom()));
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (arcs_sent < N_ITEMS || arc_reports_due.size() > 0) @(posedge clk);
    repeat (2 * MAXV + 10) @(posedge clk);

    $display("Sent %0d arcs: %0d new, %0d replaced, %0d first-full, %0d second-full",
             arcs_sent, status_tally[ST_NEW], status_tally[ST_REPLACED],
             status_tally[ST_FULL_A], status_tally[ST_FULL_B]);
    $display("Vertex table ended at %0d of %0d slots with %0d arcs stored",
             vtab_count, MAXV, link_count);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #6_000_000;
    $display("Timed out with %0d arcs sent, %0d results outstanding",
             arcs_sent, arc_reports_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
